// ===== sv/vnsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vnsc_pkg
// Shared types and constants of the nearest-seed color lookup.
// ----------------------------------------------------------------------------
package vnsc_pkg;

    localparam int MAX_SEEDS      = 8;
    localparam int IDX_W          = 3;
    localparam int COUNT_W        = 4;
    localparam int COORD_BITS_DEF = 5;
    localparam int COLOR_W        = 8;

    localparam logic [COUNT_W-1:0] SEED_COUNT_RST = COUNT_W'(7);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_color;

    // Control from the scan sequencer to the compare unit
    typedef struct packed {
        logic             clear;
        logic             cmp_vld;
        logic [IDX_W-1:0] idx;
    } t_scan_ctl;

endpackage

// ===== sv/vnsc_dist.sv =====
// ----------------------------------------------------------------------------
// vnsc_dist
// Squared distance of one seed to the pixel and running nearest-seed select.
// ----------------------------------------------------------------------------
module vnsc_dist #(
    parameter int COORD_BITS = vnsc_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  vnsc_pkg::t_scan_ctl     i_ctl,
    input  logic [COORD_BITS-1:0]   i_px,
    input  logic [COORD_BITS-1:0]   i_py,
    input  logic [COORD_BITS-1:0]   i_seed_x,
    input  logic [COORD_BITS-1:0]   i_seed_y,
    input  vnsc_pkg::t_color        i_seed_color,
    output logic [vnsc_pkg::IDX_W-1:0] o_best_idx,
    output vnsc_pkg::t_color        o_best_color
);
    import vnsc_pkg::*;

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 1;

    logic                  r_have;
    logic                  n_have;
    logic [DIST_W-1:0]     r_best_d;
    logic [DIST_W-1:0]     n_best_d;
    logic [IDX_W-1:0]      r_best_idx;
    logic [IDX_W-1:0]      n_best_idx;
    t_color                r_best_color;
    t_color                n_best_color;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SQ_W-1:0]       dx_sq;
    logic [SQ_W-1:0]       dy_sq;
    logic [DIST_W-1:0]     sq_dist;
    logic                  take;

    always_comb begin
        dx      = (i_px >= i_seed_x) ? (i_px - i_seed_x) : (i_seed_x - i_px);
        dy      = (i_py >= i_seed_y) ? (i_py - i_seed_y) : (i_seed_y - i_py);
        dx_sq   = SQ_W'(dx) * SQ_W'(dx);
        dy_sq   = SQ_W'(dy) * SQ_W'(dy);
        sq_dist = DIST_W'(dx_sq) + DIST_W'(dy_sq);
        // strict compare: on a tie the lower index stays
        take    = i_ctl.cmp_vld && (!r_have || (sq_dist < r_best_d));

        n_have       = r_have;
        n_best_d     = r_best_d;
        n_best_idx   = r_best_idx;
        n_best_color = r_best_color;
        if (i_ctl.clear) begin
            n_have = 1'b0;
        end else if (take) begin
            n_have       = 1'b1;
            n_best_d     = sq_dist;
            n_best_idx   = i_ctl.idx;
            n_best_color = i_seed_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            r_have <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_d     <= n_best_d;
        r_best_idx   <= n_best_idx;
        r_best_color <= n_best_color;
    end

    // next values include the compare of this cycle
    assign o_best_idx   = n_best_idx;
    assign o_best_color = n_best_color;

endmodule

// ===== sv/voronoi_nearest_seed_color_core.sv =====
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_color_core
// Seed table with brute-force nearest-seed color lookup.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one transaction per command.
//   A write command stores position and color in the seed table at
//   i_seed_slot and produces no result. A query command scans entries 0 ..
//   seed_count-1 (at least 0, at most 7) and returns nearest color and index.
// Output channel (o_out_valid / i_out_stall): one transaction per query.
// Config channel (i_cfg_valid / o_cfg_ready): writes seed_count; always ready.
// Timing: a write is stored when accepted. A query reads one table entry per cycle
//   from the seed memory in the scan step, then does the last compare and
//   the result load in the drain step; o_in_stall holds the next command
//   until the block is back in idle.
// Stall: the finished result waits in the output register; the block then
//   takes writes and starts the next query, which holds in its last step
//   until the output register frees.
// Reset: seed_count returns to 7, channels go empty; table contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_color_core #(
    parameter int COORD_BITS = vnsc_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vnsc_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [vnsc_pkg::IDX_W-1:0]    i_seed_slot,
    input  logic [COORD_BITS-1:0]         i_coord_x,
    input  logic [COORD_BITS-1:0]         i_coord_y,
    input  logic [vnsc_pkg::COLOR_W-1:0]  i_seed_red,
    input  logic [vnsc_pkg::COLOR_W-1:0]  i_seed_green,
    input  logic [vnsc_pkg::COLOR_W-1:0]  i_seed_blue,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [vnsc_pkg::COLOR_W-1:0]  o_pixel_red,
    output logic [vnsc_pkg::COLOR_W-1:0]  o_pixel_green,
    output logic [vnsc_pkg::COLOR_W-1:0]  o_pixel_blue,
    output logic [vnsc_pkg::IDX_W-1:0]    o_nearest_index
);
    import vnsc_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        t_color                color;
    } t_entry;

    t_entry                r_mem [MAX_SEEDS];
    t_entry                r_rd_data;

    t_state                r_state;
    t_state                n_state;
    logic [COUNT_W-1:0]    r_seed_count;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [IDX_W-1:0]      n_rd_idx;
    logic [IDX_W-1:0]      r_last_idx;
    logic [IDX_W-1:0]      n_last_idx;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_color                r_out_color;
    logic [IDX_W-1:0]      r_out_idx;

    logic                  in_accept;
    logic                  is_query;
    logic                  out_free;
    logic                  load_out;
    logic                  mem_we;
    t_entry                wr_entry;
    t_scan_ctl             scan_ctl;
    logic [IDX_W-1:0]      best_idx;
    t_color                best_color;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign is_query    = (i_command == CMD_QUERY);
    assign mem_we      = in_accept && !is_query;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        wr_entry.x           = i_coord_x;
        wr_entry.y           = i_coord_y;
        wr_entry.color.red   = i_seed_red;
        wr_entry.color.green = i_seed_green;
        wr_entry.color.blue  = i_seed_blue;
    end

    // Seed table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_seed_slot] <= wr_entry;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // Last index scanned: zero counts as one, large counts saturate
    always_comb begin
        if (r_seed_count == '0) begin
            n_last_idx = '0;
        end else if (r_seed_count >= COUNT_W'(MAX_SEEDS)) begin
            n_last_idx = IDX_W'(MAX_SEEDS - 1);
        end else begin
            n_last_idx = IDX_W'(r_seed_count - COUNT_W'(1));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        load_out    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && is_query) begin
                    n_rd_idx = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_rd_idx = r_rd_idx + IDX_W'(1);
                if (r_rd_idx == r_last_idx) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // hold the result until the output register frees
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seed_count <= SEED_COUNT_RST;
            r_rd_idx     <= '0;
            r_cmp_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_idx  <= n_rd_idx;
            r_cmp_vld <= (r_state == ST_SCAN);
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_idx;
        if (in_accept && is_query) begin
            r_px       <= i_coord_x;
            r_py       <= i_coord_y;
            r_last_idx <= n_last_idx;
        end
        if (load_out) begin
            r_out_color <= best_color;
            r_out_idx   <= best_idx;
        end
    end

    always_comb begin
        scan_ctl.clear   = in_accept && is_query;
        scan_ctl.cmp_vld = r_cmp_vld;
        scan_ctl.idx     = r_cmp_idx;
    end

    vnsc_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_px         (r_px),
        .i_py         (r_py),
        .i_seed_x     (r_rd_data.x),
        .i_seed_y     (r_rd_data.y),
        .i_seed_color (r_rd_data.color),
        .o_best_idx   (best_idx),
        .o_best_color (best_color)
    );

    assign o_out_valid     = r_out_valid;
    assign o_pixel_red     = r_out_color.red;
    assign o_pixel_green   = r_out_color.green;
    assign o_pixel_blue    = r_out_color.blue;
    assign o_nearest_index = r_out_idx;

    // A new result only appears at the end of a scan
    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_DRAIN)
        else $error("result raised outside the drain step");

    // Compare data is only live during or right after a scan
    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == ST_SCAN || r_state == ST_DRAIN))
        else $error("compare strobe outside a scan");

    // During a scan the read address never passes the last seed in use
    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_rd_idx <= r_last_idx)
        else $error("scan read beyond seed count");

    // Leaving the drain step always loads the output register
    a_drain_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && n_state == ST_IDLE) |=> o_out_valid)
        else $error("drain finished without a result");

endmodule
